// ===== hw/rtl/miller_rabin_witness_test_assert.svh =====
// ----------------------------------------------------------------------------
// Miller-Rabin witness test: assertion macros
// Shared property forms used by the witness test RTL, clocked on i_clk and
// disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MILLER_RABIN_WITNESS_TEST_ASSERT_SVH
`define MILLER_RABIN_WITNESS_TEST_ASSERT_SVH

// same-cycle implication
`define MRWT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// next-cycle implication
`define MRWT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== hw/rtl/mrwt_pkg.sv =====
// ----------------------------------------------------------------------------
// Miller-Rabin witness test: shared package
// Word widths, microcode field codes, control/status structs and the
// microprogram ROM for the witness test sequencer.
// ----------------------------------------------------------------------------
package mrwt_pkg;

    localparam int WORD_BITS = 63;
    localparam int SUM_BITS  = WORD_BITS + 1;
    localparam int CNT_BITS  = $clog2(WORD_BITS);
    localparam int PC_BITS   = 5;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [SUM_BITS-1:0]  t_sum;
    typedef logic [CNT_BITS-1:0]  t_cnt;
    typedef logic [PC_BITS-1:0]   t_pc;
    typedef logic [3:0]           t_op;
    typedef logic [1:0]           t_wsrc;
    typedef logic [3:0]           t_cond;

    localparam t_word WORD_ONE = t_word'(1);
    localparam t_word WORD_TWO = t_word'(2);

    // datapath operations
    localparam t_op OP_NOP     = 4'd0;
    localparam t_op OP_LOAD    = 4'd1;
    localparam t_op OP_INIT_U  = 4'd2;
    localparam t_op OP_SHIFT_U = 4'd3;
    localparam t_op OP_MUL_RED = 4'd4;
    localparam t_op OP_MUL_AB  = 4'd5;
    localparam t_op OP_MUL_BB  = 4'd6;
    localparam t_op OP_MUL_AA  = 4'd7;
    localparam t_op OP_WB_BASE = 4'd8;
    localparam t_op OP_WB_ACC  = 4'd9;
    localparam t_op OP_WB_SQ   = 4'd10;
    localparam t_op OP_WB_Y    = 4'd11;
    localparam t_op OP_NEXT_SQ = 4'd12;
    localparam t_op OP_EMIT0   = 4'd13;
    localparam t_op OP_EMIT1   = 4'd14;

    // hold sources
    localparam t_wsrc W_NONE = 2'd0;
    localparam t_wsrc W_IN   = 2'd1;
    localparam t_wsrc W_MUL  = 2'd2;
    localparam t_wsrc W_OUT  = 2'd3;

    // jump conditions
    localparam t_cond C_NEVER   = 4'd0;
    localparam t_cond C_ALWAYS  = 4'd1;
    localparam t_cond C_N_TWO   = 4'd2;
    localparam t_cond C_N_BAD   = 4'd3;
    localparam t_cond C_U_LSB0  = 4'd4;
    localparam t_cond C_U_ZERO  = 4'd5;
    localparam t_cond C_NONTRIV = 4'd6;
    localparam t_cond C_T_MORE  = 4'd7;
    localparam t_cond C_Y_ONE   = 4'd8;

    // microprogram step addresses
    localparam t_pc ST_IDLE     = 5'd0;
    localparam t_pc ST_CHK_TWO  = 5'd1;
    localparam t_pc ST_CHK_BAD  = 5'd2;
    localparam t_pc ST_INIT_U   = 5'd3;
    localparam t_pc ST_SPLIT    = 5'd4;
    localparam t_pc ST_RED      = 5'd5;
    localparam t_pc ST_RED_WB   = 5'd6;
    localparam t_pc ST_POW      = 5'd7;
    localparam t_pc ST_BIT      = 5'd8;
    localparam t_pc ST_MUL      = 5'd9;
    localparam t_pc ST_MUL_WB   = 5'd10;
    localparam t_pc ST_SQR      = 5'd11;
    localparam t_pc ST_SQR_WB   = 5'd12;
    localparam t_pc ST_SQ       = 5'd13;
    localparam t_pc ST_SQ_WB    = 5'd14;
    localparam t_pc ST_ROOT     = 5'd15;
    localparam t_pc ST_NEXT     = 5'd16;
    localparam t_pc ST_FINAL    = 5'd17;
    localparam t_pc ST_COMP     = 5'd18;
    localparam t_pc ST_PRIME    = 5'd19;

    typedef struct packed {
        t_op   op;
        t_wsrc wsrc;
        t_cond cond;
        t_pc   target;
    } t_uword;

    typedef struct packed {
        t_op  op;
        logic fire;
        logic in_wait;
    } t_ctrl;

    typedef struct packed {
        logic mul_busy;
        logic n_two;
        logic n_bad;
        logic u_lsb0;
        logic u_zero;
        logic nontriv;
        logic t_more;
        logic y_one;
    } t_stat;

    function automatic t_uword uw(input t_op op, input t_wsrc ws, input t_cond c,
                                  input t_pc tgt);
        t_uword w;
        w.op     = op;
        w.wsrc   = ws;
        w.cond   = c;
        w.target = tgt;
        return w;
    endfunction

    // microprogram: a jump is taken when its condition holds, else fall through
    function automatic t_uword ucode(input t_pc pc);
        t_uword w;
        case (pc)
            ST_IDLE:    w = uw(OP_LOAD,    W_IN,   C_NEVER,   ST_IDLE);
            ST_CHK_TWO: w = uw(OP_NOP,     W_NONE, C_N_TWO,   ST_PRIME);
            ST_CHK_BAD: w = uw(OP_NOP,     W_NONE, C_N_BAD,   ST_COMP);
            ST_INIT_U:  w = uw(OP_INIT_U,  W_NONE, C_NEVER,   ST_IDLE);
            ST_SPLIT:   w = uw(OP_SHIFT_U, W_NONE, C_U_LSB0,  ST_SPLIT);
            ST_RED:     w = uw(OP_MUL_RED, W_NONE, C_NEVER,   ST_IDLE);
            ST_RED_WB:  w = uw(OP_WB_BASE, W_MUL,  C_NEVER,   ST_IDLE);
            ST_POW:     w = uw(OP_NOP,     W_NONE, C_U_ZERO,  ST_SQ);
            ST_BIT:     w = uw(OP_NOP,     W_NONE, C_U_LSB0,  ST_SQR);
            ST_MUL:     w = uw(OP_MUL_AB,  W_NONE, C_NEVER,   ST_IDLE);
            ST_MUL_WB:  w = uw(OP_WB_ACC,  W_MUL,  C_NEVER,   ST_IDLE);
            ST_SQR:     w = uw(OP_MUL_BB,  W_NONE, C_NEVER,   ST_IDLE);
            ST_SQR_WB:  w = uw(OP_WB_SQ,   W_MUL,  C_ALWAYS,  ST_POW);
            ST_SQ:      w = uw(OP_MUL_AA,  W_NONE, C_NEVER,   ST_IDLE);
            ST_SQ_WB:   w = uw(OP_WB_Y,    W_MUL,  C_NEVER,   ST_IDLE);
            ST_ROOT:    w = uw(OP_NOP,     W_NONE, C_NONTRIV, ST_COMP);
            ST_NEXT:    w = uw(OP_NEXT_SQ, W_NONE, C_T_MORE,  ST_SQ);
            ST_FINAL:   w = uw(OP_NOP,     W_NONE, C_Y_ONE,   ST_PRIME);
            ST_COMP:    w = uw(OP_EMIT0,   W_OUT,  C_ALWAYS,  ST_IDLE);
            ST_PRIME:   w = uw(OP_EMIT1,   W_OUT,  C_ALWAYS,  ST_IDLE);
            default:    w = uw(OP_NOP,     W_NONE, C_ALWAYS,  ST_IDLE);
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/mrwt_mulmod.sv =====
// ----------------------------------------------------------------------------
// Shift-and-add modular multiplier
// Forms (x * y) mod n one multiplier bit per cycle; x must be below n.
// Stops as soon as the remaining multiplier bits are zero.
// ----------------------------------------------------------------------------
module mrwt_mulmod
    import mrwt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    input  t_word i_x,
    input  t_word i_y,
    input  t_word i_n,
    output logic  o_busy,
    output t_word o_res
);

    logic  r_busy;
    t_word r_acc;
    t_word r_dbl;
    t_word r_y;

    t_sum  w_nn;
    t_sum  w_acc_sum;
    t_sum  w_acc_red;
    t_sum  w_dbl_sum;
    t_sum  w_dbl_red;
    t_word n_acc;
    t_word n_dbl;
    t_word n_y;

    always_comb begin
        w_nn      = {1'b0, i_n};
        w_acc_sum = {1'b0, r_acc} + {1'b0, r_dbl};
        w_acc_red = (w_acc_sum >= w_nn) ? (w_acc_sum - w_nn) : w_acc_sum;
        w_dbl_sum = {r_dbl, 1'b0};
        w_dbl_red = (w_dbl_sum >= w_nn) ? (w_dbl_sum - w_nn) : w_dbl_sum;
        n_acc     = r_y[0] ? w_acc_red[WORD_BITS-1:0] : r_acc;
        n_dbl     = w_dbl_red[WORD_BITS-1:0];
        n_y       = r_y >> 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && (n_y == '0)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_dbl <= i_x;
            r_y   <= i_y;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_dbl <= n_dbl;
            r_y   <= n_y;
        end
    end

    assign o_busy = r_busy;
    assign o_res  = r_acc;

endmodule

// ===== hw/rtl/mrwt_seq.sv =====
// ----------------------------------------------------------------------------
// Microprogram sequencer
// Steps through the control ROM, holds a step until its wait source clears
// and takes conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module mrwt_seq
    import mrwt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_free,
    input  t_stat i_stat,
    output t_ctrl o_ctrl
);

    t_pc    r_pc;
    t_pc    n_pc;
    t_uword w_uw;
    logic   w_fire;
    logic   w_jump;

    always_comb begin
        w_uw = ucode(r_pc);

        case (w_uw.wsrc)
            W_NONE:  w_fire = 1'b1;
            W_IN:    w_fire = i_in_valid;
            W_MUL:   w_fire = !i_stat.mul_busy;
            W_OUT:   w_fire = i_out_free;
            default: w_fire = 1'b1;
        endcase

        case (w_uw.cond)
            C_NEVER:   w_jump = 1'b0;
            C_ALWAYS:  w_jump = 1'b1;
            C_N_TWO:   w_jump = i_stat.n_two;
            C_N_BAD:   w_jump = i_stat.n_bad;
            C_U_LSB0:  w_jump = i_stat.u_lsb0;
            C_U_ZERO:  w_jump = i_stat.u_zero;
            C_NONTRIV: w_jump = i_stat.nontriv;
            C_T_MORE:  w_jump = i_stat.t_more;
            C_Y_ONE:   w_jump = i_stat.y_one;
            default:   w_jump = 1'b0;
        endcase

        if (!w_fire) begin
            n_pc = r_pc;
        end else if (w_jump) begin
            n_pc = w_uw.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= ST_IDLE;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign o_ctrl.op      = w_uw.op;
    assign o_ctrl.fire    = w_fire;
    assign o_ctrl.in_wait = (w_uw.wsrc == W_IN);

endmodule

// ===== hw/rtl/mrwt_dp.sv =====
// ----------------------------------------------------------------------------
// Witness test datapath
// Holds candidate, base, power accumulator, exponent and square count,
// drives the shared modular multiplier and reports status to the sequencer.
// ----------------------------------------------------------------------------
module mrwt_dp
    import mrwt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_ctrl i_ctrl,
    input  t_word i_candidate,
    input  t_word i_witness,
    output t_stat o_stat
);

    t_word r_n;
    t_word r_b;
    t_word r_acc;
    t_word r_u;
    t_word r_y;
    t_cnt  r_t;

    logic  w_start;
    t_word w_mx;
    t_word w_my;
    logic  w_busy;
    t_word w_res;
    t_word w_nm1;

    always_comb begin
        w_start = 1'b0;
        w_mx    = r_acc;
        w_my    = r_b;
        case (i_ctrl.op)
            OP_MUL_RED: begin
                w_start = 1'b1;
                w_mx    = WORD_ONE;
                w_my    = r_b;
            end
            OP_MUL_AB: begin
                w_start = 1'b1;
                w_mx    = r_acc;
                w_my    = r_b;
            end
            OP_MUL_BB: begin
                w_start = 1'b1;
                w_mx    = r_b;
                w_my    = r_b;
            end
            OP_MUL_AA: begin
                w_start = 1'b1;
                w_mx    = r_acc;
                w_my    = r_acc;
            end
            default: begin
                w_start = 1'b0;
            end
        endcase
        w_start = w_start && i_ctrl.fire;
    end

    mrwt_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_x     (w_mx),
        .i_y     (w_my),
        .i_n     (r_n),
        .o_busy  (w_busy),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (i_ctrl.fire) begin
            case (i_ctrl.op)
                OP_LOAD: begin
                    r_n <= i_candidate;
                    r_b <= i_witness;
                end
                OP_INIT_U: begin
                    r_u <= w_nm1;
                    r_t <= '0;
                end
                OP_SHIFT_U: begin
                    if (!r_u[0]) begin
                        r_u <= r_u >> 1;
                        r_t <= r_t + 1'b1;
                    end
                end
                OP_WB_BASE: begin
                    r_b   <= w_res;
                    r_acc <= WORD_ONE;
                end
                OP_WB_ACC: begin
                    r_acc <= w_res;
                end
                OP_WB_SQ: begin
                    r_b <= w_res;
                    r_u <= r_u >> 1;
                end
                OP_WB_Y: begin
                    r_y <= w_res;
                end
                OP_NEXT_SQ: begin
                    r_acc <= r_y;
                    r_t   <= r_t - 1'b1;
                end
                default: begin
                    r_n <= r_n;
                end
            endcase
        end
    end

    assign w_nm1 = r_n - WORD_ONE;

    // a square of one from a root other than +1 or -1 proves compositeness
    assign o_stat.mul_busy = w_busy;
    assign o_stat.n_two    = (r_n == WORD_TWO);
    assign o_stat.n_bad    = !r_n[0] || (r_n == WORD_ONE);
    assign o_stat.u_lsb0   = !r_u[0];
    assign o_stat.u_zero   = (r_u == '0);
    assign o_stat.nontriv  = (r_y == WORD_ONE) && (r_acc != WORD_ONE) && (r_acc != w_nm1);
    assign o_stat.t_more   = (r_t > t_cnt'(1));
    assign o_stat.y_one    = (r_y == WORD_ONE);

endmodule

// ===== hw/rtl/miller_rabin_witness_test.sv =====
// ----------------------------------------------------------------------------
// Miller-Rabin witness test
// One Miller-Rabin round on a 63-bit candidate with one witness, run by a
// microcoded sequencer over a shared shift-and-add modular multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries a request (i_candidate, i_witness).
//   Output channel o_valid/i_ready carries the verdict: 1 probably prime for
//   this witness, 0 composite. Candidate two gives 1; zero, one and even
//   values give 0.
//   One request is worked at a time. o_ready is high only while the
//   sequencer sits at its idle step, and drops in the cycle after accept.
//   Work: a round needs one reduction of the witness, up to two
//   multiplications per exponent bit and one squaring per trailing zero of
//   candidate-1; the two counts together span at most 63 bits. All of them
//   run one after another on the single multiplier.
//   The verdict sits in an output register; the next request is accepted
//   while it waits. If the receiver stalls, the following verdict holds in
//   the sequencer until the register frees.
//   Reset (synchronous, active low) returns the sequencer to idle and empties
//   the output register.
// ----------------------------------------------------------------------------
`include "miller_rabin_witness_test_assert.svh"

module miller_rabin_witness_test
    import mrwt_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [WORD_BITS-1:0] i_candidate,
    input  logic [WORD_BITS-1:0] i_witness,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_verdict
);

    t_ctrl w_ctrl;
    t_stat w_stat;
    logic  w_out_free;
    logic  w_emit;
    logic  r_out_valid;
    logic  r_verdict;

    assign w_out_free = !r_out_valid || i_ready;

    mrwt_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_valid),
        .i_out_free (w_out_free),
        .i_stat     (w_stat),
        .o_ctrl     (w_ctrl)
    );

    mrwt_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_candidate (i_candidate),
        .i_witness   (i_witness),
        .o_stat      (w_stat)
    );

    assign w_emit = w_ctrl.fire && ((w_ctrl.op == OP_EMIT0) || (w_ctrl.op == OP_EMIT1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_verdict <= (w_ctrl.op == OP_EMIT1);
        end
    end

    assign o_ready   = w_ctrl.in_wait;
    assign o_valid   = r_out_valid;
    assign o_verdict = r_verdict;

    `MRWT_ASSERT_NXT(a_accept_leaves_idle, i_valid && o_ready, !o_ready)
    `MRWT_ASSERT_IMP(a_mul_not_idle, w_stat.mul_busy, !o_ready)
    `MRWT_ASSERT_IMP(a_out_from_emit, $rose(o_valid), $past(w_emit))

endmodule

// ===== test/miller_rabin_witness_test_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Miller-Rabin witness test: verdict checker
// Watches both channels of the witness test, works out the verdict of every
// accepted request with its own single-round model and compares each
// delivered verdict against the oldest one outstanding.
// ----------------------------------------------------------------------------
module miller_rabin_witness_test_checker
    import mrwt_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    input  logic  i_req_ready,
    input  t_word i_req_candidate,
    input  t_word i_req_witness,
    input  logic  i_res_valid,
    input  logic  i_res_ready,
    input  logic  i_res_verdict,
    output int    o_fail_count,
    output int    o_pending,
    output int    o_checked,
    output int    o_probable
);

    typedef struct {
        t_word candidate;
        t_word witness;
        logic  verdict;
    } t_round;

    t_round expected_verdicts[$];

    // (x * y) mod n, shift-and-add; x must already be below n
    function automatic t_sum mod_mul(input t_sum x, input t_sum y, input t_sum n);
        t_sum acc;
        t_sum dbl;
        int   i;
        acc = '0;
        dbl = x;
        for (i = 0; i < WORD_BITS; i++) begin
            if (y[i]) begin
                acc = acc + dbl;
                if (acc >= n) acc = acc - n;
            end
            dbl = dbl << 1;
            if (dbl >= n) dbl = dbl - n;
        end
        return acc;
    endfunction

    function automatic t_sum mod_pow(input t_sum base, input t_sum e, input t_sum n);
        t_sum acc;
        t_sum sq;
        int   i;
        acc = t_sum'(1);
        sq  = base;
        for (i = 0; i < WORD_BITS; i++) begin
            if (e[i]) acc = mod_mul(acc, sq, n);
            sq = mod_mul(sq, sq, n);
        end
        return acc;
    endfunction

    function automatic logic round_verdict(input t_word candidate, input t_word witness);
        t_sum n;
        t_sum u;
        t_sum x;
        t_sum y;
        int   t;
        int   j;
        n = t_sum'(candidate);
        if (n == t_sum'(2)) return 1'b1;
        if (n < t_sum'(2) || !n[0]) return 1'b0;
        u = n - 1;
        t = 0;
        while (!u[0] && t < WORD_BITS) begin
            u = u >> 1;
            t++;
        end
        x = mod_pow(t_sum'(witness) % n, u, n);
        y = x;
        for (j = 0; j < t; j++) begin
            y = mod_mul(x, x, n);
            // a square root of one other than +1 / -1 proves the candidate composite
            if (y == t_sum'(1) && x != t_sum'(1) && x != n - 1) return 1'b0;
            x = y;
        end
        return (y == t_sum'(1));
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
        o_probable   = 0;
    end

    always @(posedge i_clk) begin
        t_round exp_round;
        t_round req_round;
        if (i_rst_n) begin
            if (i_req_valid && i_req_ready) begin
                req_round.candidate = i_req_candidate;
                req_round.witness   = i_req_witness;
                req_round.verdict   = round_verdict(i_req_candidate, i_req_witness);
                expected_verdicts.push_back(req_round);
            end
            if (i_res_valid && i_res_ready) begin
                if (expected_verdicts.size() == 0) begin
                    $display("%0t: verdict with no request outstanding: expected none, got %0b",
                             $time, i_res_verdict);
                    o_fail_count++;
                end else begin
                    exp_round = expected_verdicts.pop_front();
                    o_checked++;
                    if (i_res_verdict) o_probable++;
                    if (i_res_verdict !== exp_round.verdict) begin
                        $display("%0t: verdict for n=%0d a=%0d: expected %0b, got %0b",
                                 $time, exp_round.candidate, exp_round.witness,
                                 exp_round.verdict, i_res_verdict);
                        o_fail_count++;
                    end
                end
            end
            o_pending = expected_verdicts.size();
        end
    end

endmodule

// ===== test/miller_rabin_witness_test_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Miller-Rabin witness test: testbench
// Drives directed corner cases, then mostly odd random candidates, known primes
// and strong pseudoprimes, mostly with random witnesses, under random gaps and
// stalls; the checker beside the block predicts and compares every verdict.
// ----------------------------------------------------------------------------
module miller_rabin_witness_test_tb;
    import mrwt_pkg::*;

    localparam int RANDOM_REQUESTS = 80;

    logic  i_clk;
    logic  i_rst_n;
    logic  i_valid;
    logic  o_ready;
    t_word i_candidate;
    t_word i_witness;
    logic  o_valid;
    logic  i_ready;
    logic  o_verdict;

    int fail_count;
    int pending;
    int checked;
    int probable;
    int sent;
    bit steady;

    miller_rabin_witness_test u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_candidate (i_candidate),
        .i_witness   (i_witness),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_verdict   (o_verdict)
    );

    miller_rabin_witness_test_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_ready     (o_ready),
        .i_req_candidate (i_candidate),
        .i_req_witness   (i_witness),
        .i_res_valid     (o_valid),
        .i_res_ready     (i_ready),
        .i_res_verdict   (o_verdict),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_probable      (probable)
    );

    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver stalls at random, except through the steady stretch
    always @(negedge i_clk) begin
        if (steady) i_ready = 1'b1;
        else i_ready = ($urandom_range(0, 99) >= 37);
    end

    initial begin
        #200_000_000;
        $display("miller_rabin_witness_test: mismatch");
        $finish;
    end

    function automatic t_word random_word();
        return t_word'({$urandom, $urandom});
    endfunction

    // witness in 1 .. n-1
    function automatic t_word witness_below(input t_word n);
        return t_word'((t_sum'(random_word()) % t_sum'(n - 1)) + 1);
    endfunction

    function automatic t_word prime_like(input int idx);
        case (idx)
            0:       return t_word'(65521);
            1:       return t_word'(1000003);
            2:       return t_word'(64'd2147483647);
            3:       return t_word'(64'd4294967291);
            4:       return t_word'(64'd1000000007);
            5:       return t_word'(64'd2305843009213693951);
            6:       return t_word'(64'd9223372036854775783);
            7:       return t_word'(2047);
            8:       return t_word'(25326001);
            9:       return t_word'(64'd3215031751);
            10:      return t_word'(64'd3825123056546413051);
            default: return t_word'(561);
        endcase
    endfunction

    // enter and leave at a falling edge; valid stays up between back-to-back requests
    task automatic send_request(input t_word n, input t_word w);
        while (!steady && $urandom_range(0, 99) < 37) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid     = 1'b1;
        i_candidate = n;
        i_witness   = w;
        do @(posedge i_clk); while (!o_ready);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        t_word n;
        t_word w;
        int    kind;
        int    k;

        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        i_candidate = '0;
        i_witness   = '0;
        sent        = 0;
        steady      = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        // corner cases
        send_request('0, '0);
        send_request(WORD_ONE, t_word'(5));
        send_request(WORD_TWO, '0);
        send_request(WORD_TWO, '1);
        send_request(t_word'(4), t_word'(3));
        send_request(t_word'(64'd9223372036854775806), t_word'(7));
        send_request(t_word'(3), WORD_TWO);
        send_request(t_word'(3), t_word'(3));
        send_request(t_word'(9), '0);
        send_request(t_word'(9), t_word'(18));
        send_request(t_word'(7), WORD_ONE);
        send_request(t_word'(7), t_word'(6));
        send_request(t_word'(561), WORD_TWO);
        send_request(t_word'(2047), WORD_TWO);
        send_request(t_word'(2047), t_word'(3));
        send_request(t_word'(64'd4611686018427387905), t_word'(3));
        send_request('1, '1);
        send_request(t_word'(64'd2305843009213693951), t_word'(3));
        send_request(t_word'(64'd9223372036854775783), '1);
        send_request(t_word'(64'd3215031751), t_word'(7));
        send_request(t_word'(64'd3825123056546413051), WORD_TWO);
        send_request(t_word'(65521), '1);
        send_request(t_word'(64'd1000000007), t_word'(5));
        drain();

        for (k = 0; k < RANDOM_REQUESTS; k++) begin
            steady = (k >= 30 && k < 55);
            // hold off until every verdict is back
            if (k == 60) drain();
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
                n = t_word'($urandom_range(3, 65535)) | WORD_ONE;
                w = witness_below(n);
            end else if (kind < 60) begin
                n = t_word'($urandom) | WORD_ONE;
                if (n == WORD_ONE) n = t_word'(3);
                w = witness_below(n);
            end else if (kind < 72) begin
                n = prime_like($urandom_range(0, 11));
                w = witness_below(n);
            end else if (kind < 84) begin
                n = random_word() | WORD_ONE;
                w = witness_below(n);
            end else if (kind < 92) begin
                n = t_word'($urandom_range(3, 65535)) | WORD_ONE;
                w = random_word();
            end else begin
                case ($urandom_range(0, 3))
                    0: begin
                        n = random_word() & ~WORD_ONE;
                        w = random_word();
                    end
                    1: begin
                        n = t_word'($urandom_range(0, 2));
                        w = random_word();
                    end
                    2: begin
                        n = t_word'($urandom_range(3, 4095)) | WORD_ONE;
                        w = n * t_word'($urandom_range(0, 1000));
                    end
                    default: begin
                        n = t_word'($urandom_range(3, 65535)) | WORD_ONE;
                        w = n - 1;
                    end
                endcase
            end
            send_request(n, w);
        end
        steady = 1'b0;

        drain();
        repeat (100) @(negedge i_clk);

        $display("Covered %0d requests: corner cases, primes, strong pseudoprimes, random odd.",
                 sent);
        $display("Checked %0d verdicts, %0d of them probably prime.", checked, probable);
        if (fail_count == 0 && pending == 0) begin
            $display("miller_rabin_witness_test: match");
        end else begin
            $display("miller_rabin_witness_test: mismatch");
        end
        $finish;
    end

endmodule
